>>> sv/oriented_box_point_classifier_defines.svh
// ----------------------------------------------------------------------------
// Oriented box point classifier: assertion macros
// Shared helpers for the concurrent checks in the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_POINT_CLASSIFIER_DEFINES_SVH
`define ORIENTED_BOX_POINT_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define OBPC_CHECK_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define OBPC_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/obpc_pkg.sv
// ----------------------------------------------------------------------------
// Oriented box point classifier package
// Widths, register indexes and the flag word carried down the pipeline.
// ----------------------------------------------------------------------------
package obpc_pkg;

    localparam int COORD_BITS     = 24;
    localparam int TRIG_BITS      = 16;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int MARGIN_BITS    = 17;
    localparam int DIST_BITS      = 25;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COORD_BITS;

    // Datapath widths.
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = DIFF_BITS + TRIG_BITS;
    localparam int LOCAL_BITS = PROD_BITS + 1;
    localparam int MAG_BITS   = LOCAL_BITS;
    localparam int CLAMP_BITS = MARGIN_BITS - 1;
    localparam int ZW_BITS    = COORD_BITS + 1;
    localparam int SPAN_BITS  = COORD_BITS + 2;
    localparam int LIM_BITS   = SPAN_BITS + TRIG_FRAC_BITS - 1;
    localparam int RND_BITS   = MAG_BITS + 1;
    localparam int EXC_BITS   = RND_BITS - TRIG_FRAC_BITS;
    localparam int SQ_BITS    = 2 * DIST_BITS;
    localparam int SUM_BITS   = SQ_BITS + 1;
    localparam int ROOT_BITS  = (SUM_BITS + 1) / 2;
    localparam int RAD_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 3;

    // Upper bound on the distance for a point inside the widened box.
    localparam int INSIDE_DIST_BOUND = 2 * ((1 << (MARGIN_BITS - 1)) - 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COS_YAW    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIN_YAW    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_LENGTH = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MIN_Z  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MAX_Z  = 3'd7;

    typedef struct packed {
        logic ok;
        logic z_in;
        logic xy_in;
    } t_flags;

endpackage

>>> sv/oriented_box_point_classifier.sv
// ----------------------------------------------------------------------------
// Oriented box point classifier
// Classifies a stream of 3D points against one yaw-rotated box. Each point is
// rotated into box coordinates, tested against the box widened by its own
// margins, and given its 2D distance to the box outline. The pipeline takes
// one word per clock while the output is not stalled. Its stages, in order:
// eight stages for offset, rotation, local coordinates, magnitude, excess,
// rounding, squaring and sum, then one stage per root bit of the 26-bit
// square root, then the output register. Stalls hold the whole pipeline; a
// new word is accepted in any cycle in which the output register is empty or
// its word is taken.
// ----------------------------------------------------------------------------
`include "oriented_box_point_classifier_defines.svh"

module oriented_box_point_classifier (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [obpc_pkg::CFG_IDX_BITS-1:0]        i_cfg_idx,
    input  logic [obpc_pkg::CFG_DATA_BITS-1:0]       i_cfg_data,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic signed [obpc_pkg::COORD_BITS-1:0]   i_point_x,
    input  logic signed [obpc_pkg::COORD_BITS-1:0]   i_point_y,
    input  logic signed [obpc_pkg::COORD_BITS-1:0]   i_point_z,
    input  logic signed [obpc_pkg::MARGIN_BITS-1:0]  i_widen_xy,
    input  logic signed [obpc_pkg::MARGIN_BITS-1:0]  i_widen_z,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic                                     o_inside_res,
    output logic [obpc_pkg::DIST_BITS-1:0]           o_outline_distance,
    output logic                                     o_box_ok
);

    localparam int FRONT_STAGES = 8;
    localparam int STAGES       = FRONT_STAGES + obpc_pkg::ROOT_BITS + 1;
    localparam int LAST         = STAGES - 1;
    localparam int HALF_SHIFT   = obpc_pkg::TRIG_FRAC_BITS - 1;

    // Configuration registers.
    logic signed [obpc_pkg::COORD_BITS-1:0] r_center_x;
    logic signed [obpc_pkg::COORD_BITS-1:0] r_center_y;
    logic signed [obpc_pkg::TRIG_BITS-1:0]  r_cos_yaw;
    logic signed [obpc_pkg::TRIG_BITS-1:0]  r_sin_yaw;
    logic        [obpc_pkg::COORD_BITS-1:0] r_box_length;
    logic        [obpc_pkg::COORD_BITS-1:0] r_box_width;
    logic signed [obpc_pkg::COORD_BITS-1:0] r_box_min_z;
    logic signed [obpc_pkg::COORD_BITS-1:0] r_box_max_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_cos_yaw    <= obpc_pkg::TRIG_BITS'(1) << obpc_pkg::TRIG_FRAC_BITS;
            r_sin_yaw    <= '0;
            r_box_length <= '0;
            r_box_width  <= '0;
            r_box_min_z  <= '0;
            r_box_max_z  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                obpc_pkg::CFG_CENTER_X:   r_center_x   <= i_cfg_data;
                obpc_pkg::CFG_CENTER_Y:   r_center_y   <= i_cfg_data;
                obpc_pkg::CFG_COS_YAW:    r_cos_yaw    <= i_cfg_data[obpc_pkg::TRIG_BITS-1:0];
                obpc_pkg::CFG_SIN_YAW:    r_sin_yaw    <= i_cfg_data[obpc_pkg::TRIG_BITS-1:0];
                obpc_pkg::CFG_BOX_LENGTH: r_box_length <= i_cfg_data;
                obpc_pkg::CFG_BOX_WIDTH:  r_box_width  <= i_cfg_data;
                obpc_pkg::CFG_BOX_MIN_Z:  r_box_min_z  <= i_cfg_data;
                obpc_pkg::CFG_BOX_MAX_Z:  r_box_max_z  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control: one enable for all stages.
    logic              adv;
    logic              in_take;
    logic              out_take;
    logic [STAGES-1:0] r_vld;

    assign adv        = !r_vld[LAST] || !i_out_stall;
    assign in_take    = i_in_valid && adv;
    assign out_take   = r_vld[LAST] && !i_out_stall;
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAST-1:0], i_in_valid};
        end
    end

    // Stage 1: offset from the box center, clamp margins, box check.
    logic signed [obpc_pkg::DIFF_BITS-1:0]   n_p1_dx, n_p1_dy;
    logic        [obpc_pkg::CLAMP_BITS-1:0]  n_p1_mxy, n_p1_mz;
    obpc_pkg::t_flags                        n_p1_flags;
    logic signed [obpc_pkg::DIFF_BITS-1:0]   r_p1_dx, r_p1_dy;
    logic        [obpc_pkg::CLAMP_BITS-1:0]  r_p1_mxy, r_p1_mz;
    logic signed [obpc_pkg::COORD_BITS-1:0]  r_p1_pz;
    obpc_pkg::t_flags                        r_p1_flags;

    always_comb begin
        n_p1_dx  = obpc_pkg::DIFF_BITS'(i_point_x) - obpc_pkg::DIFF_BITS'(r_center_x);
        n_p1_dy  = obpc_pkg::DIFF_BITS'(i_point_y) - obpc_pkg::DIFF_BITS'(r_center_y);
        n_p1_mxy = i_widen_xy[obpc_pkg::MARGIN_BITS-1] ? '0
                 : i_widen_xy[obpc_pkg::CLAMP_BITS-1:0];
        n_p1_mz  = i_widen_z[obpc_pkg::MARGIN_BITS-1] ? '0
                 : i_widen_z[obpc_pkg::CLAMP_BITS-1:0];
        n_p1_flags.ok    = (r_box_length != '0) && (r_box_width != '0)
                         && (r_box_max_z > r_box_min_z);
        n_p1_flags.z_in  = 1'b0;
        n_p1_flags.xy_in = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_dx    <= n_p1_dx;
            r_p1_dy    <= n_p1_dy;
            r_p1_mxy   <= n_p1_mxy;
            r_p1_mz    <= n_p1_mz;
            r_p1_pz    <= i_point_z;
            r_p1_flags <= n_p1_flags;
        end
    end

    // Stage 2: rotation products, height test, widened spans.
    logic signed [obpc_pkg::ZW_BITS-1:0]    n_zlo, n_zhi, n_pz;
    obpc_pkg::t_flags                       n_p2_flags;
    logic signed [obpc_pkg::PROD_BITS-1:0]  r_p2_cdx, r_p2_sdy, r_p2_cdy, r_p2_sdx;
    logic        [obpc_pkg::SPAN_BITS-1:0]  r_p2_span_x, r_p2_span_y;
    obpc_pkg::t_flags                       r_p2_flags;

    always_comb begin
        n_zlo = obpc_pkg::ZW_BITS'(r_box_min_z)
              - obpc_pkg::ZW_BITS'($signed({1'b0, r_p1_mz}));
        n_zhi = obpc_pkg::ZW_BITS'(r_box_max_z)
              + obpc_pkg::ZW_BITS'($signed({1'b0, r_p1_mz}));
        n_pz  = obpc_pkg::ZW_BITS'(r_p1_pz);
        n_p2_flags      = r_p1_flags;
        n_p2_flags.z_in = (n_pz >= n_zlo) && (n_pz <= n_zhi);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_cdx    <= obpc_pkg::PROD_BITS'(r_cos_yaw) * obpc_pkg::PROD_BITS'(r_p1_dx);
            r_p2_sdy    <= obpc_pkg::PROD_BITS'(r_sin_yaw) * obpc_pkg::PROD_BITS'(r_p1_dy);
            r_p2_cdy    <= obpc_pkg::PROD_BITS'(r_cos_yaw) * obpc_pkg::PROD_BITS'(r_p1_dy);
            r_p2_sdx    <= obpc_pkg::PROD_BITS'(r_sin_yaw) * obpc_pkg::PROD_BITS'(r_p1_dx);
            r_p2_span_x <= obpc_pkg::SPAN_BITS'(r_box_length)
                         + (obpc_pkg::SPAN_BITS'(r_p1_mxy) << 1);
            r_p2_span_y <= obpc_pkg::SPAN_BITS'(r_box_width)
                         + (obpc_pkg::SPAN_BITS'(r_p1_mxy) << 1);
            r_p2_flags  <= n_p2_flags;
        end
    end

    // Stage 3: local coordinates, scaled by 2^TRIG_FRAC_BITS.
    logic signed [obpc_pkg::LOCAL_BITS-1:0] r_p3_lx, r_p3_ly;
    logic        [obpc_pkg::SPAN_BITS-1:0]  r_p3_span_x, r_p3_span_y;
    obpc_pkg::t_flags                       r_p3_flags;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3_lx     <= obpc_pkg::LOCAL_BITS'(r_p2_cdx) + obpc_pkg::LOCAL_BITS'(r_p2_sdy);
            r_p3_ly     <= obpc_pkg::LOCAL_BITS'(r_p2_cdy) - obpc_pkg::LOCAL_BITS'(r_p2_sdx);
            r_p3_span_x <= r_p2_span_x;
            r_p3_span_y <= r_p2_span_y;
            r_p3_flags  <= r_p2_flags;
        end
    end

    // Stage 4: magnitudes of the local coordinates.
    logic [obpc_pkg::MAG_BITS-1:0]  r_p4_mag_x, r_p4_mag_y;
    logic [obpc_pkg::SPAN_BITS-1:0] r_p4_span_x, r_p4_span_y;
    obpc_pkg::t_flags               r_p4_flags;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p4_mag_x  <= r_p3_lx[obpc_pkg::LOCAL_BITS-1] ? obpc_pkg::MAG_BITS'(-r_p3_lx)
                         : obpc_pkg::MAG_BITS'(r_p3_lx);
            r_p4_mag_y  <= r_p3_ly[obpc_pkg::LOCAL_BITS-1] ? obpc_pkg::MAG_BITS'(-r_p3_ly)
                         : obpc_pkg::MAG_BITS'(r_p3_ly);
            r_p4_span_x <= r_p3_span_x;
            r_p4_span_y <= r_p3_span_y;
            r_p4_flags  <= r_p3_flags;
        end
    end

    // Stage 5: widened-box test and excess beyond the plain half sizes.
    logic [obpc_pkg::LIM_BITS-1:0] lim_x, lim_y;
    logic [obpc_pkg::MAG_BITS-1:0] half_x, half_y;
    logic [obpc_pkg::MAG_BITS-1:0] n_p5_ex, n_p5_ey;
    obpc_pkg::t_flags              n_p5_flags;
    logic [obpc_pkg::MAG_BITS-1:0] r_p5_ex, r_p5_ey;
    obpc_pkg::t_flags              r_p5_flags;

    always_comb begin
        lim_x  = obpc_pkg::LIM_BITS'(r_p4_span_x) << HALF_SHIFT;
        lim_y  = obpc_pkg::LIM_BITS'(r_p4_span_y) << HALF_SHIFT;
        half_x = obpc_pkg::MAG_BITS'(r_box_length) << HALF_SHIFT;
        half_y = obpc_pkg::MAG_BITS'(r_box_width) << HALF_SHIFT;
        n_p5_ex = (r_p4_mag_x > half_x) ? r_p4_mag_x - half_x : '0;
        n_p5_ey = (r_p4_mag_y > half_y) ? r_p4_mag_y - half_y : '0;
        n_p5_flags       = r_p4_flags;
        n_p5_flags.xy_in = (r_p4_mag_x <= obpc_pkg::MAG_BITS'(lim_x))
                        && (r_p4_mag_y <= obpc_pkg::MAG_BITS'(lim_y));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p5_ex    <= n_p5_ex;
            r_p5_ey    <= n_p5_ey;
            r_p5_flags <= n_p5_flags;
        end
    end

    // Stage 6: round the excess to whole millimetres, half up, and saturate.
    logic [obpc_pkg::RND_BITS-1:0]  rnd_x, rnd_y;
    logic [obpc_pkg::EXC_BITS-1:0]  exc_x, exc_y;
    logic [obpc_pkg::DIST_BITS-1:0] r_p6_ex, r_p6_ey;
    obpc_pkg::t_flags               r_p6_flags;

    always_comb begin
        rnd_x = obpc_pkg::RND_BITS'(r_p5_ex) + (obpc_pkg::RND_BITS'(1) << HALF_SHIFT);
        rnd_y = obpc_pkg::RND_BITS'(r_p5_ey) + (obpc_pkg::RND_BITS'(1) << HALF_SHIFT);
        exc_x = rnd_x[obpc_pkg::RND_BITS-1:obpc_pkg::TRIG_FRAC_BITS];
        exc_y = rnd_y[obpc_pkg::RND_BITS-1:obpc_pkg::TRIG_FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p6_ex    <= (|exc_x[obpc_pkg::EXC_BITS-1:obpc_pkg::DIST_BITS]) ? '1
                        : exc_x[obpc_pkg::DIST_BITS-1:0];
            r_p6_ey    <= (|exc_y[obpc_pkg::EXC_BITS-1:obpc_pkg::DIST_BITS]) ? '1
                        : exc_y[obpc_pkg::DIST_BITS-1:0];
            r_p6_flags <= r_p5_flags;
        end
    end

    // Stages 7 and 8: squares, then their sum.
    logic [obpc_pkg::SQ_BITS-1:0]  r_p7_sq_x, r_p7_sq_y;
    obpc_pkg::t_flags              r_p7_flags;
    logic [obpc_pkg::SUM_BITS-1:0] r_p8_sum;
    obpc_pkg::t_flags              r_p8_flags;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p7_sq_x  <= obpc_pkg::SQ_BITS'(r_p6_ex) * obpc_pkg::SQ_BITS'(r_p6_ex);
            r_p7_sq_y  <= obpc_pkg::SQ_BITS'(r_p6_ey) * obpc_pkg::SQ_BITS'(r_p6_ey);
            r_p7_flags <= r_p6_flags;
            r_p8_sum   <= obpc_pkg::SUM_BITS'(r_p7_sq_x) + obpc_pkg::SUM_BITS'(r_p7_sq_y);
            r_p8_flags <= r_p7_flags;
        end
    end

    // Square root, one result bit per stage, restoring digit recurrence.
    // The remainder never exceeds twice the partial root.
    logic [obpc_pkg::RAD_BITS-1:0]  r_sq_rad   [obpc_pkg::ROOT_BITS];
    logic [obpc_pkg::ROOT_BITS-1:0] r_sq_root  [obpc_pkg::ROOT_BITS];
    logic [obpc_pkg::REM_BITS-1:0]  r_sq_rem   [obpc_pkg::ROOT_BITS];
    obpc_pkg::t_flags               r_sq_flags [obpc_pkg::ROOT_BITS];

    for (genvar j = 0; j < obpc_pkg::ROOT_BITS; j++) begin : g_root
        localparam int K = obpc_pkg::ROOT_BITS - 1 - j;

        logic [obpc_pkg::RAD_BITS-1:0]  rad_in;
        logic [obpc_pkg::ROOT_BITS-1:0] root_in;
        logic [obpc_pkg::REM_BITS-1:0]  rem_in;
        obpc_pkg::t_flags               flags_in;
        logic [obpc_pkg::REM_BITS-1:0]  rem_sh, trial;
        logic [obpc_pkg::ROOT_BITS-1:0] n_root;
        logic [obpc_pkg::REM_BITS-1:0]  n_rem;

        if (j == 0) begin : g_first
            assign rad_in   = obpc_pkg::RAD_BITS'(r_p8_sum);
            assign root_in  = '0;
            assign rem_in   = '0;
            assign flags_in = r_p8_flags;
        end else begin : g_next
            assign rad_in   = r_sq_rad[j-1];
            assign root_in  = r_sq_root[j-1];
            assign rem_in   = r_sq_rem[j-1];
            assign flags_in = r_sq_flags[j-1];
        end

        always_comb begin
            rem_sh = {rem_in[obpc_pkg::REM_BITS-3:0], rad_in[2*K+1 -: 2]};
            trial  = obpc_pkg::REM_BITS'({root_in, 2'b01});
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {root_in[obpc_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {root_in[obpc_pkg::ROOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_rad[j]   <= rad_in;
                r_sq_root[j]  <= n_root;
                r_sq_rem[j]   <= n_rem;
                r_sq_flags[j] <= flags_in;
            end
        end
    end

    // Output stage: round the root to nearest, saturate, apply box validity.
    logic [obpc_pkg::ROOT_BITS-1:0]  root_f;
    logic [obpc_pkg::REM_BITS-1:0]   rem_f;
    obpc_pkg::t_flags                flags_f;
    logic [obpc_pkg::ROOT_BITS:0]    root_rnd;
    logic [obpc_pkg::DIST_BITS-1:0]  n_out_dist;
    logic                            r_out_inside;
    logic [obpc_pkg::DIST_BITS-1:0]  r_out_dist;
    logic                            r_out_ok;

    always_comb begin
        root_f   = r_sq_root[obpc_pkg::ROOT_BITS-1];
        rem_f    = r_sq_rem[obpc_pkg::ROOT_BITS-1];
        flags_f  = r_sq_flags[obpc_pkg::ROOT_BITS-1];
        root_rnd = (obpc_pkg::ROOT_BITS+1)'(root_f)
                 + (obpc_pkg::ROOT_BITS+1)'(rem_f > obpc_pkg::REM_BITS'(root_f));
        if (!flags_f.ok || (|root_rnd[obpc_pkg::ROOT_BITS:obpc_pkg::DIST_BITS])) begin
            n_out_dist = '1;
        end else begin
            n_out_dist = root_rnd[obpc_pkg::DIST_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_inside <= flags_f.ok && flags_f.z_in && flags_f.xy_in;
            r_out_dist   <= n_out_dist;
            r_out_ok     <= flags_f.ok;
        end
    end

    assign o_out_valid        = r_vld[LAST];
    assign o_inside_res       = r_out_inside;
    assign o_outline_distance = r_out_dist;
    assign o_box_ok           = r_out_ok;

    // Every accepted word is either still in flight or has been delivered.
    `OBPC_CHECK_NOW(a_word_count, i_clk, i_rst_n, $past(i_rst_n), $countones(r_vld) == $past($countones(r_vld)) + $past(in_take) - $past(out_take), "pipeline lost or duplicated a word")

    // A word for an unusable box reports outside and a saturated distance.
    `OBPC_CHECK_NOW(a_bad_box, i_clk, i_rst_n, o_out_valid && !o_box_ok, !o_inside_res && (&o_outline_distance), "invalid box gave a usable result")

    // Inside the widened box the excess on each axis is within the margin, so the distance is within INSIDE_DIST_BOUND.
    `OBPC_CHECK_NOW(a_inside_near, i_clk, i_rst_n, o_out_valid && o_inside_res, o_outline_distance <= obpc_pkg::DIST_BITS'(obpc_pkg::INSIDE_DIST_BOUND), "inside point reported far from box")

    // A stalled output word stays valid until it is taken.
    `OBPC_CHECK_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall && $past(i_rst_n), o_out_valid, "output word dropped while stalled")

endmodule
